// ===== hw/rtl/hsv2rgb_pkg.sv =====
// hsv2rgb_pkg: shared types and constants for the hsv to rgb converter
// no dependencies; imported by hsv_to_rgb_converter_core
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  localparam int HUE_W      = 16;
  localparam int CH_W       = 8;
  localparam int HDEG_W     = 9;
  localparam int SECTOR_DEG = 60;
  localparam int SECTOR_CNT = 6;

  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  saturation;
    logic [CH_W-1:0]  brightness;
  } hsv_in_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_out_t;

  typedef enum logic [2:0] {
    SEC_RED_YEL,
    SEC_YEL_GRN,
    SEC_GRN_CYA,
    SEC_CYA_BLU,
    SEC_BLU_MAG,
    SEC_MAG_RED
  } sector_t;

  // floor(x / 255) for x up to 255 * 255, by shift and add
  function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] x);
    logic [2*CH_W:0] sum;
    sum = (2*CH_W+1)'(x) + (2*CH_W+1)'(x[2*CH_W-1:CH_W]) + (2*CH_W+1)'(1);
    return sum[2*CH_W-1:CH_W];
  endfunction

endpackage

// ===== hw/rtl/hsv_to_rgb_converter_core.sv =====
// hsv_to_rgb_converter_core: eight-stage pipeline from hue, saturation and
// brightness to 8-bit red, green and blue. Takes one transaction per clock when
// the output side keeps up. The stages are the hue reduction by reciprocal
// multiply (three stages), the sector split, and two rounds of 8x8 multiply
// followed by a divide by 255. Each stage holds its own valid bit and takes new
// data whenever it is empty or the stage after it moves, so empty stages fill
// up while a result waits on out_stall, and in_stall rises only when all stages
// are occupied. Hue is reduced modulo HUE_RANGE; saturation and brightness
// above SAT_FULL and BRT_FULL are clamped. Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_core
  import hsv2rgb_pkg::*;
#(
  parameter int HUE_RANGE = 360,
  parameter int SAT_FULL  = 100,
  parameter int BRT_FULL  = 100
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  hsv_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output rgb_out_t out_data
);

  localparam int NSTG    = 8;
  localparam int LUT_N   = 1 << CH_W;
  localparam int RECIP   = (1 << HUE_W) / HUE_RANGE;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = HUE_W + RECIP_W;
  localparam int QR_W    = RECIP_W + HDEG_W;
  localparam int MUL_W   = 2 * CH_W;

  // handshake and valid chain
  logic [NSTG:1] vld_r;
  logic [NSTG:1] vld_nxt;
  logic [NSTG:1] vld_in;
  logic [NSTG:1] rdy;

  always_comb begin
    rdy[NSTG] = !vld_r[NSTG] || !out_stall;
    for (int k = NSTG - 1; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign vld_in  = {vld_r[NSTG-1:1], in_valid};
  assign vld_nxt = (rdy & vld_in) | (~rdy & vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !rdy[1];
  assign out_valid = vld_r[NSTG];

  // scaling tables for saturation and brightness, clamp included
  logic [CH_W-1:0] sat_lut [LUT_N];
  logic [CH_W-1:0] brt_lut [LUT_N];

  for (genvar i = 0; i < LUT_N; i++) begin : g_lut
    localparam int SAT_V = ((i > SAT_FULL) ? SAT_FULL : i) * int'(CH_MAX) / SAT_FULL;
    localparam int BRT_V = ((i > BRT_FULL) ? BRT_FULL : i) * int'(CH_MAX) / BRT_FULL;
    assign sat_lut[i] = CH_W'(SAT_V);
    assign brt_lut[i] = CH_W'(BRT_V);
  end

  // stage 1: quotient estimate of hue by reciprocal, s and v lookup
  logic [PROD_W-1:0]  prod1_nxt;
  logic [HUE_W-1:0]   h1_r;
  logic [RECIP_W-1:0] qe1_r;
  logic [CH_W-1:0]    s1_r, v1_r;

  assign prod1_nxt = PROD_W'(in_data.hue) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      h1_r  <= in_data.hue;
      qe1_r <= prod1_nxt[HUE_W +: RECIP_W];
      s1_r  <= sat_lut[in_data.saturation];
      v1_r  <= brt_lut[in_data.brightness];
    end
  end

  // stage 2: quotient estimate times range
  logic [QR_W-1:0]  qr2_nxt;
  logic [HUE_W-1:0] h2_r, qr2_r;
  logic [CH_W-1:0]  s2_r, v2_r;

  assign qr2_nxt = QR_W'(qe1_r) * QR_W'(HUE_RANGE);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      h2_r  <= h1_r;
      qr2_r <= qr2_nxt[HUE_W-1:0];
      s2_r  <= s1_r;
      v2_r  <= v1_r;
    end
  end

  // stage 3: remainder with one correction step
  logic [HUE_W-1:0]  rem3_c;
  logic [HUE_W-1:0]  hr3_c;
  logic [HDEG_W-1:0] hr3_r;
  logic [CH_W-1:0]   s3_r, v3_r;

  always_comb begin
    rem3_c = h2_r - qr2_r;
    if (rem3_c >= HUE_W'(HUE_RANGE)) begin
      hr3_c = rem3_c - HUE_W'(HUE_RANGE);
    end else begin
      hr3_c = rem3_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      hr3_r <= hr3_c[HDEG_W-1:0];
      s3_r  <= s2_r;
      v3_r  <= v2_r;
    end
  end

  // stage 4: sector and fraction, f = (h mod 60) * 17 / 4
  logic [2:0]        cnt4_c;
  logic [HDEG_W-1:0] hm4_c;
  logic [10:0]       f17_c;
  sector_t           sec4_r;
  logic [CH_W-1:0]   f4_r, s4_r, v4_r;

  always_comb begin
    cnt4_c = '0;
    for (int i = 1; i < SECTOR_CNT; i++) begin
      if (hr3_r >= HDEG_W'(i * SECTOR_DEG)) begin
        cnt4_c = cnt4_c + 3'd1;
      end
    end
    hm4_c = hr3_r - HDEG_W'(int'(cnt4_c) * SECTOR_DEG);
    f17_c = {1'b0, hm4_c[5:0], 4'b0000} + 11'(hm4_c[5:0]);
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      sec4_r <= sector_t'(cnt4_c);
      f4_r   <= f17_c[9:2];
      s4_r   <= s3_r;
      v4_r   <= v3_r;
    end
  end

  // stage 5: f*s, (255-f)*s, v*(255-s)
  sector_t          sec5_r;
  logic [MUL_W-1:0] fs5_r, ts5_r, ps5_r;
  logic [CH_W-1:0]  v5_r;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      sec5_r <= sec4_r;
      fs5_r  <= MUL_W'(f4_r) * MUL_W'(s4_r);
      ts5_r  <= MUL_W'(CH_MAX - f4_r) * MUL_W'(s4_r);
      ps5_r  <= MUL_W'(v4_r) * MUL_W'(CH_MAX - s4_r);
      v5_r   <= v4_r;
    end
  end

  // stage 6: divide by 255
  sector_t         sec6_r;
  logic [CH_W-1:0] a6_r, b6_r, p6_r, v6_r;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      sec6_r <= sec5_r;
      a6_r   <= div255(fs5_r);
      b6_r   <= div255(ts5_r);
      p6_r   <= div255(ps5_r);
      v6_r   <= v5_r;
    end
  end

  // stage 7: v*(255-a) and v*(255-b)
  sector_t          sec7_r;
  logic [MUL_W-1:0] qm7_r, tm7_r;
  logic [CH_W-1:0]  p7_r, v7_r;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      sec7_r <= sec6_r;
      qm7_r  <= MUL_W'(v6_r) * MUL_W'(CH_MAX - a6_r);
      tm7_r  <= MUL_W'(v6_r) * MUL_W'(CH_MAX - b6_r);
      p7_r   <= p6_r;
      v7_r   <= v6_r;
    end
  end

  // stage 8: final divide and channel order
  logic [CH_W-1:0] q8_c, t8_c;
  rgb_out_t        out_nxt;
  rgb_out_t        out_r;

  always_comb begin
    q8_c = div255(qm7_r);
    t8_c = div255(tm7_r);
    unique case (sec7_r)
      SEC_RED_YEL: out_nxt = '{red: v7_r, green: t8_c, blue: p7_r};
      SEC_YEL_GRN: out_nxt = '{red: q8_c, green: v7_r, blue: p7_r};
      SEC_GRN_CYA: out_nxt = '{red: p7_r, green: v7_r, blue: t8_c};
      SEC_CYA_BLU: out_nxt = '{red: p7_r, green: q8_c, blue: v7_r};
      SEC_BLU_MAG: out_nxt = '{red: t8_c, green: p7_r, blue: v7_r};
      default:     out_nxt = '{red: v7_r, green: p7_r, blue: q8_c};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

`ifndef SYNTHESIS
  // input backs up only with every stage full and the output held
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&vld_r) && out_stall))
    else $error("in_stall with a free pipeline stage");

  // accepted transaction lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[1])
    else $error("accepted transaction lost at stage 1");

  // reduced hue stays below the range
  a_hue_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] |-> (hr3_r < HDEG_W'(HUE_RANGE)))
    else $error("hue reduction out of range");

  // output drains when nothing is behind it
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !vld_r[NSTG-1]) |=> !out_valid)
    else $error("result repeated on output");
`endif

endmodule

// ===== tb/tb_hsv_to_rgb_converter_core.sv =====
// tb_hsv_to_rgb_converter_core: self-checking bench for the hsv to rgb pipeline,
// a directed color table then random colors, checked by table value or a color model
// depends on hsv2rgb_pkg and hsv_to_rgb_converter_core
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter_core;
  import hsv2rgb_pkg::*;

  localparam int HUE_DEG   = 360;
  localparam int SAT_MAX   = 100;
  localparam int BRT_MAX   = 100;
  localparam int HOLD_CYC  = 80;
  localparam int N_RANDOM  = 550;
  localparam int N_ROWS    = 22;

  typedef struct {
    hsv_in_t  color;
    bit       known;
    rgb_out_t rgb;
  } color_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  hsv_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  rgb_out_t out_data;

  rgb_out_t rgb_expected_q[$];
  int       mismatch_cnt;
  int       sent_cnt;
  int       checked_cnt;
  int       backpressure_cnt;
  bit       tx_idle;
  bit       rx_idle;
  bit       hold_req;

  color_row_t color_table [N_ROWS] = '{
    '{'{16'd0,     8'd0,   8'd0},   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{'{16'd0,     8'd0,   8'd100}, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{'{16'd0,     8'd100, 8'd100}, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{'{16'd60,    8'd100, 8'd100}, 1'b1, '{8'd255, 8'd255, 8'd0}},
    '{'{16'd120,   8'd100, 8'd100}, 1'b1, '{8'd0,   8'd255, 8'd0}},
    '{'{16'd180,   8'd100, 8'd100}, 1'b1, '{8'd0,   8'd255, 8'd255}},
    '{'{16'd240,   8'd100, 8'd100}, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{'{16'd300,   8'd100, 8'd100}, 1'b1, '{8'd255, 8'd0,   8'd255}},
    '{'{16'd360,   8'd100, 8'd100}, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{'{16'd0,     8'd255, 8'd255}, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{'{16'd0,     8'd0,   8'd255}, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{'{16'd65535, 8'd0,   8'd0},   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{'{16'd0,     8'd100, 8'd0},   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{'{16'd30,    8'd50,  8'd50},  1'b0, '{8'd0,   8'd0,   8'd0}},
    '{'{16'd90,    8'd77,  8'd33},  1'b0, '{8'd0,   8'd0,   8'd0}},
    '{'{16'd150,   8'd64,  8'd99},  1'b0, '{8'd0,   8'd0,   8'd0}},
    '{'{16'd210,   8'd100, 8'd80},  1'b0, '{8'd0,   8'd0,   8'd0}},
    '{'{16'd270,   8'd25,  8'd100}, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{'{16'd330,   8'd90,  8'd60},  1'b0, '{8'd0,   8'd0,   8'd0}},
    '{'{16'd359,   8'd100, 8'd100}, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{'{16'd65535, 8'd255, 8'd255}, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{'{16'd32768, 8'd101, 8'd101}, 1'b0, '{8'd0,   8'd0,   8'd0}}
  };

  hsv_to_rgb_converter_core #(
    .HUE_RANGE(HUE_DEG),
    .SAT_FULL (SAT_MAX),
    .BRT_FULL (BRT_MAX)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic rgb_out_t rgb_from_hsv(hsv_in_t c);
    int unsigned full;
    int unsigned h;
    int unsigned sat;
    int unsigned brt;
    int unsigned v;
    int unsigned s;
    int unsigned f;
    int unsigned p;
    int unsigned q;
    int unsigned t;
    sector_t     sec;
    rgb_out_t    o;
    full = CH_MAX;
    h    = c.hue % HUE_DEG;
    sat  = (c.saturation > SAT_MAX) ? SAT_MAX : c.saturation;
    brt  = (c.brightness > BRT_MAX) ? BRT_MAX : c.brightness;
    v    = brt * full / BRT_MAX;
    s    = sat * full / SAT_MAX;
    sec  = sector_t'(h / SECTOR_DEG);
    f    = (h % SECTOR_DEG) * full / SECTOR_DEG;
    p    = v * (full - s) / full;
    q    = v * (full - (f * s) / full) / full;
    t    = v * (full - ((full - f) * s) / full) / full;
    case (sec)
      SEC_RED_YEL: o = '{CH_W'(v), CH_W'(t), CH_W'(p)};
      SEC_YEL_GRN: o = '{CH_W'(q), CH_W'(v), CH_W'(p)};
      SEC_GRN_CYA: o = '{CH_W'(p), CH_W'(v), CH_W'(t)};
      SEC_CYA_BLU: o = '{CH_W'(p), CH_W'(q), CH_W'(v)};
      SEC_BLU_MAG: o = '{CH_W'(t), CH_W'(p), CH_W'(v)};
      default:     o = '{CH_W'(v), CH_W'(p), CH_W'(q)};
    endcase
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic hsv_in_t random_color();
    hsv_in_t c;
    int      r;
    r = $urandom_range(0, 99);
    if (r < 70) c.hue = HUE_W'($urandom_range(0, HUE_DEG - 1));
    else if (r < 90) c.hue = HUE_W'($urandom_range(0, 65535));
    else c.hue = HUE_W'(SECTOR_DEG * $urandom_range(0, SECTOR_CNT) - $urandom_range(0, 1));
    c.saturation = ($urandom_range(0, 4) == 0) ? CH_W'($urandom_range(0, 255))
                                               : CH_W'($urandom_range(0, SAT_MAX));
    c.brightness = ($urandom_range(0, 4) == 0) ? CH_W'($urandom_range(0, 255))
                                               : CH_W'($urandom_range(0, BRT_MAX));
    return c;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  task automatic offer_color(hsv_in_t c, rgb_out_t want);
    int gap;
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rgb_expected_q.push_back(want);
    sent_cnt++;
    gap = tx_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rgb_expected_q.size() != 0) @(posedge clk);
  endtask

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 99) < 25) begin
        n = pick_gap() + 1;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    rgb_out_t want;
    if (rst_n && in_valid && in_stall) backpressure_cnt++;
    if (rst_n && out_valid && !out_stall) begin
      if (rgb_expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction %h", out_data));
      end else begin
        want = rgb_expected_q.pop_front();
        checked_cnt++;
        if (out_data.red !== want.red)
          report_mismatch($sformatf("red %0d, want %0d", out_data.red, want.red));
        if (out_data.green !== want.green)
          report_mismatch($sformatf("green %0d, want %0d", out_data.green, want.green));
        if (out_data.blue !== want.blue)
          report_mismatch($sformatf("blue %0d, want %0d", out_data.blue, want.blue));
      end
    end
  end

  initial begin
    hsv_in_t c;
    mismatch_cnt     = 0;
    sent_cnt         = 0;
    checked_cnt      = 0;
    backpressure_cnt = 0;
    tx_idle          = 1'b1;
    rx_idle          = 1'b1;
    hold_req         = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (color_table[i]) begin
      offer_color(color_table[i].color,
                  color_table[i].known ? color_table[i].rgb : rgb_from_hsv(color_table[i].color));
    end
    drain_pipeline();

    for (int i = 0; i < N_RANDOM; i++) begin
      case (i)
        110: begin
          tx_idle = 1'b0;
          rx_idle = 1'b0;
        end
        220: begin
          // long receiver hold-off while the sender keeps streaming
          hold_req = 1'b1;
        end
        330: begin
          tx_idle = 1'b1;
          rx_idle = 1'b1;
          drain_pipeline();
        end
        440: begin
          tx_idle = 1'b0;
          drain_pipeline();
        end
        default: ;
      endcase
      c = random_color();
      offer_color(c, rgb_from_hsv(c));
    end

    drain_pipeline();
    repeat (20) @(posedge clk);
    if (rgb_expected_q.size() != 0)
      report_mismatch($sformatf("%0d transactions never came out", rgb_expected_q.size()));
    $display("sent %0d colors (table of %0d, then random), checked %0d results",
             sent_cnt, N_ROWS, checked_cnt);
    $display("input held back for %0d cycles, %0d mismatches", backpressure_cnt,
             mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/hsv2rgb_pkg.sv
hw/rtl/hsv_to_rgb_converter_core.sv
tb/tb_hsv_to_rgb_converter_core.sv
